@@ rtl/sparse_matrix_vector_multiply_core_assert.svh @@
// Assertion macros for the sparse matrix-vector multiply core.
// Included by the checker module; no other dependencies.
`ifndef SPARSE_MATRIX_VECTOR_MULTIPLY_CORE_ASSERT_SVH
`define SPARSE_MATRIX_VECTOR_MULTIPLY_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smv assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define SMV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smv assertion failed: next-cycle implication");

`endif

@@ rtl/smv_pkg.sv @@
// Shared constants and types for the sparse matrix-vector multiply core.
// No dependencies; used by the MAC, the top level and the checker.
`timescale 1ns / 1ps

package smv_pkg;

   localparam int IDX_W            = 10;
   localparam int DATA_W           = 32;
   localparam int ROW_W            = 16;
   localparam int VECTOR_DEPTH_DEF = 1024;
   localparam int MAX_ROWS_DEF     = 65536;

   typedef enum logic [1:0] {
      KIND_LOAD    = 2'd0,
      KIND_NONZERO = 2'd1,
      KIND_END_ROW = 2'd2,
      KIND_START   = 2'd3
   } kind_type;

   // A word after the vector-store read has been issued.
   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic              hit;
      logic [DATA_W-1:0] value;
   } s1_type;

endpackage

@@ rtl/smv_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module smv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/smv_mac.sv @@
// Multiply-accumulate back end: product stage, row sum, row counter and result register.
// Depends on smv_pkg.
`timescale 1ns / 1ps

module smv_mac #(
   parameter int MAX_ROWS = smv_pkg::MAX_ROWS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  smv_pkg::s1_type                  s1,
   input  logic [smv_pkg::DATA_W-1:0]       rd_data,
   output logic                             stall,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [smv_pkg::ROW_W-1:0]        rsp_row_index,
   output logic signed [smv_pkg::DATA_W-1:0] rsp_row_sum
);

   localparam int CW = smv_pkg::ROW_W + 1;

   logic                        s2_valid_ff;
   smv_pkg::kind_type           s2_kind_ff;
   logic [smv_pkg::DATA_W-1:0]  s2_prod_ff;
   logic [smv_pkg::DATA_W-1:0]  operand;
   logic [smv_pkg::DATA_W-1:0]  prod_in;

   logic [smv_pkg::DATA_W-1:0]  sum_ff;
   logic [smv_pkg::DATA_W-1:0]  sum_in;
   logic [smv_pkg::ROW_W-1:0]   row_ff;
   logic [smv_pkg::ROW_W-1:0]   row_in;
   logic [CW-1:0]               row_wide;
   logic [smv_pkg::ROW_W-1:0]   row_next;

   logic                        rsp_valid_ff;
   logic [smv_pkg::ROW_W-1:0]   rsp_row_ff;
   logic [smv_pkg::DATA_W-1:0]  rsp_sum_ff;

   logic                        out_free;
   logic                        advance;
   logic                        retire;

   // Only an end-of-row word needs the result register; everything else retires freely.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign stall    = s2_valid_ff && (s2_kind_ff == smv_pkg::KIND_END_ROW) && !out_free;
   assign advance  = !stall;
   assign retire   = s2_valid_ff && advance;

   // A column beyond the store reads as zero.
   assign operand = s1.hit ? rd_data : '0;
   assign prod_in = s1.value * operand;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1.valid;
         s2_kind_ff  <= s1.kind;
         s2_prod_ff  <= prod_in;
      end
   end

   assign row_wide = CW'(row_ff) + CW'(1);
   assign row_next = (row_wide >= CW'(MAX_ROWS)) ? '0 : row_wide[smv_pkg::ROW_W-1:0];

   always_comb begin
      sum_in = sum_ff;
      row_in = row_ff;
      if (retire) begin
         case (s2_kind_ff)
            smv_pkg::KIND_NONZERO: begin
               sum_in = sum_ff + s2_prod_ff;
            end
            smv_pkg::KIND_END_ROW: begin
               sum_in = '0;
               row_in = row_next;
            end
            smv_pkg::KIND_START: begin
               sum_in = '0;
               row_in = '0;
            end
            default: begin
               sum_in = sum_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         row_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (retire && (s2_kind_ff == smv_pkg::KIND_END_ROW)) begin
         rsp_valid_ff <= 1'b1;
         rsp_row_ff   <= row_ff;
         rsp_sum_ff   <= sum_ff;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_row_sum   = $signed(rsp_sum_ff);

endmodule

@@ rtl/sparse_matrix_vector_multiply_core.sv @@
// Top level of the CSR sparse matrix-vector multiply core.
// Depends on smv_pkg, smv_ram and smv_mac.
//
//  channel | ports                                    | direction
//  --------+------------------------------------------+----------
//  req     | req_valid req_ready req_kind req_index   | in
//          | req_value                                |
//  rsp     | rsp_valid rsp_ready rsp_row_index        | out
//          | rsp_row_sum                              |
//
// One input word is taken every cycle while req_ready is high; the pipeline has three stages:
// store access, multiply, accumulate. A row result reaches rsp through the stage-1, product
// and result registers. Reset is synchronous and clears the pipeline, row sum and row counter;
// the vector store is not cleared and holds nothing meaningful until loaded. req_ready drops
// only while an end-of-row word waits in the last stage and the result register is still full.
`timescale 1ns / 1ps

module sparse_matrix_vector_multiply_core #(
   parameter int VECTOR_DEPTH = smv_pkg::VECTOR_DEPTH_DEF,
   parameter int MAX_ROWS     = smv_pkg::MAX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_kind,
   input  logic [smv_pkg::IDX_W-1:0]         req_index,
   input  logic signed [smv_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [smv_pkg::ROW_W-1:0]         rsp_row_index,
   output logic signed [smv_pkg::DATA_W-1:0] rsp_row_sum
);

   localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

   smv_pkg::kind_type           kind;
   logic                        hit;
   logic [AW-1:0]               addr;
   logic                        stall;
   logic                        advance;
   logic                        accept;
   logic                        wr_en;
   logic [smv_pkg::DATA_W-1:0]  rd_data;
   smv_pkg::s1_type             s1_ff;
   smv_pkg::s1_type             s1_in;

   assign kind    = smv_pkg::kind_type'(req_kind);
   // Positions at or beyond the store depth are ignored for loads and read as zero.
   assign hit     = (32'(req_index) < 32'(VECTOR_DEPTH));
   assign addr    = AW'(req_index);

   assign advance   = !stall;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // A load writes at its accept edge, so a nonzero word in the next cycle already reads
   // the new value; the two accesses never fall in the same cycle.
   assign wr_en = accept && (kind == smv_pkg::KIND_LOAD) && hit;

   smv_ram #(
      .WIDTH (smv_pkg::DATA_W),
      .DEPTH (VECTOR_DEPTH)
   ) u_vector_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data ($unsigned(req_value)),
      .rd_en   (advance),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_in.valid = accept;
      s1_in.kind  = kind;
      s1_in.hit   = hit;
      s1_in.value = $unsigned(req_value);
   end

   // Held together with the store's read register during a stall.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff <= s1_in;
      end
   end

   smv_mac #(
      .MAX_ROWS (MAX_ROWS)
   ) u_mac (
      .clock         (clock),
      .reset         (reset),
      .s1            (s1_ff),
      .rd_data       (rd_data),
      .stall         (stall),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_row_index (rsp_row_index),
      .rsp_row_sum   (rsp_row_sum)
   );

endmodule

@@ rtl/smv_checker.sv @@
// Port-level checks for the sparse matrix-vector multiply core, bound to the top level.
// Depends on smv_pkg and sparse_matrix_vector_multiply_core_assert.svh.
`timescale 1ns / 1ps
`include "sparse_matrix_vector_multiply_core_assert.svh"

module smv_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [smv_pkg::ROW_W-1:0]         rsp_row_index,
   input logic signed [smv_pkg::DATA_W-1:0] rsp_row_sum
);

   // Reset empties the result register.
   `SMV_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)

   // Input back-pressure comes only from a blocked result.
   `SMV_ASSERT_NOW(a_ready_low_only_when_blocked, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // A waiting result stays and keeps its payload.
   `SMV_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row_index) && $stable(rsp_row_sum))

endmodule

bind sparse_matrix_vector_multiply_core smv_checker u_smv_checker (.*);

@@ test/tb_top.sv @@
// Self-checking testbench for the CSR sparse matrix-vector multiply core.
// Depends on smv_pkg and sparse_matrix_vector_multiply_core; needs nothing else.
`timescale 1ns / 1ps

module tb_top;

   // The index field is ten bits wide, so at the default depth every index lands
   // inside the vector store.
   localparam int STORE_DEPTH  = smv_pkg::VECTOR_DEPTH_DEF;
   localparam int RANDOM_WORDS = 300;
   localparam int DRAIN_CYCLES = 10;
   // A correct run keeps moving words; even a long
   // streak of receiver stalls at 48 % never comes near this many quiet cycles.
   localparam int STALL_LIMIT  = 5000;

   typedef struct packed {
      smv_pkg::kind_type          kind;
      logic [smv_pkg::IDX_W-1:0]  index;
      logic [smv_pkg::DATA_W-1:0] value;
   } matrix_word_type;

   typedef struct packed {
      logic [smv_pkg::ROW_W-1:0]  row;
      logic [smv_pkg::DATA_W-1:0] sum;
   } row_result_type;

   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [1:0]                        req_kind  = '0;
   logic [smv_pkg::IDX_W-1:0]         req_index = '0;
   logic signed [smv_pkg::DATA_W-1:0] req_value = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [smv_pkg::ROW_W-1:0]         rsp_row_index;
   logic signed [smv_pkg::DATA_W-1:0] rsp_row_sum;

   sparse_matrix_vector_multiply_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_index     (req_index),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_row_index (rsp_row_index),
      .rsp_row_sum   (rsp_row_sum)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor: a private image of the vector store, the running row sum and the
   // row counter, advanced by every word the block takes. Each end-of-row word
   // leaves the row it closes in expected_rows, oldest first.
   // ---------------------------------------------------------------------------
   logic [smv_pkg::DATA_W-1:0] vector_image [STORE_DEPTH];
   logic [smv_pkg::DATA_W-1:0] sum_so_far = '0;
   logic [smv_pkg::ROW_W-1:0]  row_number = '0;
   row_result_type             expected_rows [$];

   task automatic absorb_word(input matrix_word_type w);
      logic [smv_pkg::DATA_W-1:0] product;
      row_result_type             closed;
      case (w.kind)
         smv_pkg::KIND_LOAD: begin
            vector_image[w.index] = w.value;
         end
         smv_pkg::KIND_NONZERO: begin
            // Only the low 32 bits of the product count, so signedness plays no part.
            product    = w.value * vector_image[w.index];
            sum_so_far = sum_so_far + product;
         end
         smv_pkg::KIND_END_ROW: begin
            closed.row = row_number;
            closed.sum = sum_so_far;
            expected_rows.push_back(closed);
            sum_so_far = '0;
            if (int'(row_number) + 1 >= smv_pkg::MAX_ROWS_DEF) begin
               row_number = '0;
            end else begin
               row_number = row_number + 1'b1;
            end
         end
         default: begin
            sum_so_far = '0;
            row_number = '0;
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus store. The generator remembers which vector entries it has loaded,
   // so that a nonzero word never reads an entry that was never written.
   // ---------------------------------------------------------------------------
   matrix_word_type word_queue [$];
   bit              col_loaded [STORE_DEPTH];
   int              loaded_cols [$];

   int send_gap_pct   = 34;
   int recv_stall_pct = 48;
   int words_sent     = 0;
   int words_taken    = 0;
   int quiet_cycles   = 0;
   int error_count    = 0;

   function automatic void queue_word(smv_pkg::kind_type k,
                                      logic [smv_pkg::IDX_W-1:0] idx,
                                      logic [smv_pkg::DATA_W-1:0] val);
      word_queue.push_back(matrix_word_type'{kind: k, index: idx, value: val});
   endfunction

   function automatic void queue_load(logic [smv_pkg::IDX_W-1:0] idx,
                                      logic [smv_pkg::DATA_W-1:0] val);
      queue_word(smv_pkg::KIND_LOAD, idx, val);
      if (!col_loaded[idx]) begin
         col_loaded[idx] = 1'b1;
         loaded_cols.push_back(int'(idx));
      end
   endfunction

   function automatic logic [smv_pkg::IDX_W-1:0] loaded_column();
      return smv_pkg::IDX_W'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
   endfunction

   function automatic logic [smv_pkg::IDX_W-1:0] random_index();
      return smv_pkg::IDX_W'($urandom_range(STORE_DEPTH - 1));
   endfunction

   // Mostly uniform values, with the awkward corners of the signed range mixed in.
   function automatic logic [smv_pkg::DATA_W-1:0] random_value();
      if ($urandom_range(7) != 0) begin
         return $urandom;
      end
      case ($urandom_range(4))
         0:       return 32'h0000_0000;
         1:       return 32'h0000_0001;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h8000_0000;
         default: return 32'h7FFF_FFFF;
      endcase
   endfunction

   // Mostly well-formed rows of random length over loaded columns. The rest is
   // bursts of vector loads, stray starts and stray words, and rows broken by a
   // start or a reload part-way through.
   task automatic queue_random_words(input int count);
      int made;
      int pick;
      int len;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            len = $urandom_range(1, 8);
            repeat (len) queue_load(random_index(), random_value());
            made += len;
         end else if (pick < 12) begin
            queue_word(smv_pkg::KIND_START, random_index(), $urandom);
            made++;
         end else if (pick < 16) begin
            if ($urandom_range(1) == 0) begin
               queue_word(smv_pkg::KIND_NONZERO, loaded_column(), random_value());
            end else begin
               queue_word(smv_pkg::KIND_END_ROW, random_index(), $urandom);
            end
            made++;
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
            repeat (len) begin
               pick = $urandom_range(99);
               if (pick < 8) begin
                  queue_load(random_index(), random_value());
               end else if (pick < 11) begin
                  queue_word(smv_pkg::KIND_START, random_index(), $urandom);
               end else begin
                  queue_word(smv_pkg::KIND_NONZERO, loaded_column(), random_value());
               end
            end
            queue_word(smv_pkg::KIND_END_ROW, random_index(), $urandom);
            made += len + 1;
         end
      end
   endtask

   task automatic wait_for_drain();
      while (word_queue.size() != 0 || words_sent != words_taken ||
             expected_rows.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Driver: everything changes on the falling edge. A word stays on the port,
   // valid high, until the rising-edge monitor has counted it as taken.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      matrix_word_type w;
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         if (words_sent == words_taken) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               w = word_queue.pop_front();
               req_kind  <= w.kind;
               req_index <= w.index;
               req_value <= w.value;
               req_valid <= 1'b1;
               words_sent++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: both handshakes are sampled on the rising edge. A taken word feeds
   // the predictor before the result channel is checked, so the expectation for
   // a row is always queued before its result could be compared.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      row_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            absorb_word(matrix_word_type'{kind: smv_pkg::kind_type'(req_kind),
                                          index: req_index, value: req_value});
            words_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rows.size() == 0) begin
               $display("%t: unexpected row result, row %0d sum %h", $time,
                        rsp_row_index, rsp_row_sum);
               error_count++;
            end else begin
               want = expected_rows.pop_front();
               if (rsp_row_index !== want.row) begin
                  $display("%t: row_index mismatch, expected %0d actual %0d", $time,
                           want.row, rsp_row_index);
                  error_count++;
               end
               if (rsp_row_sum !== want.sum) begin
                  $display("%t: row_sum mismatch on row %0d, expected %h actual %h",
                           $time, want.row, want.sum, rsp_row_sum);
                  error_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   // Watchdog: a block that stops moving words ends the run as a failure.
   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("%t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Sequencer: directed words first, then three random phases with different
   // idling on each side.
   // ---------------------------------------------------------------------------
   initial begin
      // Loads at both ends of the store and with the extreme values.
      queue_load(10'd0,    32'h8000_0000);
      queue_load(10'd1023, 32'h7FFF_FFFF);
      queue_load(10'd1,    32'hFFFF_FFFF);
      queue_load(10'd2,    32'h0000_0001);
      // An empty row reports a zero sum; index and value are ignored here.
      queue_word(smv_pkg::KIND_END_ROW, 10'h3FF, 32'hFFFF_FFFF);
      // Extreme products, a reload part-way through a row, and a wrapping sum.
      queue_word(smv_pkg::KIND_NONZERO, 10'd0,    32'h7FFF_FFFF);
      queue_word(smv_pkg::KIND_NONZERO, 10'd1023, 32'h8000_0000);
      queue_load(10'd2, 32'h7FFF_FFFF);
      queue_word(smv_pkg::KIND_NONZERO, 10'd2,    32'h7FFF_FFFF);
      queue_word(smv_pkg::KIND_NONZERO, 10'd1,    32'hFFFF_FFFF);
      queue_word(smv_pkg::KIND_END_ROW, 10'd0, 32'd0);
      // A start in the middle of a row drops the partial sum and the row count.
      queue_word(smv_pkg::KIND_NONZERO, 10'd1, 32'h8000_0000);
      queue_word(smv_pkg::KIND_START, 10'h3FF, 32'hFFFF_FFFF);
      queue_word(smv_pkg::KIND_END_ROW, 10'h155, 32'h5555_5555);
      // Zero and unit matrix values.
      queue_word(smv_pkg::KIND_NONZERO, 10'd1023, 32'd0);
      queue_word(smv_pkg::KIND_NONZERO, 10'd1023, 32'd1);
      queue_word(smv_pkg::KIND_END_ROW, 10'h2AA, 32'hAAAA_AAAA);
      // Overwriting an entry with zero makes its later products vanish.
      queue_load(10'd0, 32'd0);
      queue_word(smv_pkg::KIND_NONZERO, 10'd0, 32'hFFFF_FFFF);
      queue_word(smv_pkg::KIND_END_ROW, 10'd0, 32'd0);
      // Back-to-back starts, then a row straight after them.
      queue_word(smv_pkg::KIND_START, 10'd0, 32'd0);
      queue_word(smv_pkg::KIND_START, 10'h3FF, 32'h7FFF_FFFF);
      queue_word(smv_pkg::KIND_END_ROW, 10'd0, 32'd0);

      queue_random_words(RANDOM_WORDS);

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      wait_for_drain();

      send_gap_pct   = 48;
      recv_stall_pct = 34;
      queue_random_words(RANDOM_WORDS);
      wait_for_drain();

      send_gap_pct   = 0;
      recv_stall_pct = 0;
      queue_random_words(RANDOM_WORDS);
      wait_for_drain();

      // Any result the block still produces now has no expectation and counts.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
